@@ rtl/core/gcdc_pkg.sv @@
`default_nettype none

package gcdc_pkg;

   // Field widths fixed by the stream format
   localparam int BYTE_W   = 8;
   localparam int SIZE_W   = 24;
   localparam int MASK_W   = 64;
   localparam int CAUSE_W  = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // Cut causes
   localparam logic [CAUSE_W-1:0] CAUSE_STRICT = 2'd0;
   localparam logic [CAUSE_W-1:0] CAUSE_LOOSE  = 2'd1;
   localparam logic [CAUSE_W-1:0] CAUSE_MAX    = 2'd2;
   localparam logic [CAUSE_W-1:0] CAUSE_EOS    = 2'd3;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SIZE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NORMAL_SIZE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_SIZE    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STRICT_MASK = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOSE_MASK  = 3'd4;

   // Reset values of the control registers
   localparam logic [SIZE_W-1:0] MIN_SIZE_RST    = 24'd262144;
   localparam logic [SIZE_W-1:0] NORMAL_SIZE_RST = 24'd1048576;
   localparam logic [SIZE_W-1:0] MAX_SIZE_RST    = 24'd4194304;
   localparam logic [MASK_W-1:0] STRICT_MASK_RST = {{22{1'b1}}, {42{1'b0}}};
   localparam logic [MASK_W-1:0] LOOSE_MASK_RST  = {{18{1'b1}}, {46{1'b0}}};

   // Gear table generator constants
   localparam int GEAR_DEPTH = 256;
   localparam logic [63:0] GOLDEN_STEP = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL_A   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL_B   = 64'h94D049BB133111EB;
   localparam logic [63:0] GEAR_SEED   = 64'h1234567890ABCDEF;

   typedef logic [MASK_W-1:0] gear_rom_type [GEAR_DEPTH];

   typedef struct packed {
      logic [SIZE_W-1:0] min_size;
      logic [SIZE_W-1:0] normal_size;
      logic [SIZE_W-1:0] max_size;
      logic [MASK_W-1:0] strict_mask;
      logic [MASK_W-1:0] loose_mask;
   } cfg_type;

   // Build the gear table from successive splitmix64 outputs
   function automatic gear_rom_type gear_rom_build();
      gear_rom_type rom;
      logic [63:0] seed;
      logic [63:0] z;
      seed = GEAR_SEED;
      for (int k = 0; k < GEAR_DEPTH; k++) begin
         seed = seed + GOLDEN_STEP;
         z = seed;
         z = (z ^ (z >> 30)) * MIX_MUL_A;
         z = (z ^ (z >> 27)) * MIX_MUL_B;
         rom[k] = z ^ (z >> 31);
      end
      return rom;
   endfunction

endpackage

`default_nettype wire

@@ rtl/core/gcdc_req_if.sv @@
`default_nettype none

interface gcdc_req_if;
   logic                           valid;
   logic                           ready;
   logic [gcdc_pkg::BYTE_W-1:0]    data_byte;
   logic                           end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gcdc_rsp_if.sv @@
`default_nettype none

interface gcdc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [gcdc_pkg::SIZE_W-1:0]    chunk_length;
   logic [gcdc_pkg::CAUSE_W-1:0]   cut_cause;

   modport source (output valid, output chunk_length, output cut_cause, input ready);
   modport sink   (input valid, input chunk_length, input cut_cause, output ready);
endinterface

`default_nettype wire

@@ rtl/core/gcdc_csr.sv @@
`default_nettype none

module gcdc_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_write_enable,
   input  wire [gcdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [gcdc_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output gcdc_pkg::cfg_type                   cfg
);

   gcdc_pkg::cfg_type cfg_ff;
   gcdc_pkg::cfg_type cfg_in;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            gcdc_pkg::CSR_MIN_SIZE:
               cfg_in.min_size = csr_write_data[gcdc_pkg::SIZE_W-1:0];
            gcdc_pkg::CSR_NORMAL_SIZE:
               cfg_in.normal_size = csr_write_data[gcdc_pkg::SIZE_W-1:0];
            gcdc_pkg::CSR_MAX_SIZE:
               cfg_in.max_size = csr_write_data[gcdc_pkg::SIZE_W-1:0];
            gcdc_pkg::CSR_STRICT_MASK:
               cfg_in.strict_mask = csr_write_data[gcdc_pkg::MASK_W-1:0];
            gcdc_pkg::CSR_LOOSE_MASK:
               cfg_in.loose_mask = csr_write_data[gcdc_pkg::MASK_W-1:0];
            default: ;
         endcase
      end
   end

   // Hold the registers, load defaults on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_size    <= gcdc_pkg::MIN_SIZE_RST;
         cfg_ff.normal_size <= gcdc_pkg::NORMAL_SIZE_RST;
         cfg_ff.max_size    <= gcdc_pkg::MAX_SIZE_RST;
         cfg_ff.strict_mask <= gcdc_pkg::STRICT_MASK_RST;
         cfg_ff.loose_mask  <= gcdc_pkg::LOOSE_MASK_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/core/gear_content_defined_chunker.sv @@
`default_nettype none

// Content-defined chunker with a 64-bit gear fingerprint and two-level masks.
// Bytes of the stream arrive on req_chan, one request per byte, with
// end_of_stream set on the final byte. Each closed chunk leaves on rsp_chan
// as its length and the cause of the cut. Control registers (min, normal and
// max size, strict and loose mask) are written through the csr_ port; the user
// must write them only while the block is idle, which the block does not
// enforce. A write takes effect at the next clock edge. A byte is accepted into
// an input register, then hashed and tested against the masks; any resulting
// chunk goes to the result register that drives rsp_chan. One byte per cycle
// is sustained unless rsp_chan stalls: the fingerprint loop, a 64-bit shift-add
// fed by the 256-entry gear table and a masked zero test, is combinational.
// When the receiver stalls, the result register holds its chunk and the input
// register holds one more byte; req_chan.ready drops only when both are full.
// Synchronous reset clears both registers' valid flags, the fingerprint and
// the chunk position, and restores the register defaults.
module gear_content_defined_chunker #(
   parameter int LENGTH_BITS = 24
) (
   input  wire                                 clock,
   input  wire                                 reset,
   gcdc_req_if.sink                            req_chan,
   gcdc_rsp_if.source                          rsp_chan,
   input  wire                                 csr_write_enable,
   input  wire [gcdc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire [gcdc_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   localparam int CMP_W = ((LENGTH_BITS > gcdc_pkg::SIZE_W) ?
                           LENGTH_BITS : gcdc_pkg::SIZE_W) + 1;
   localparam logic [LENGTH_BITS:0] LEN_LIMIT = {1'b0, {LENGTH_BITS{1'b1}}};
   localparam gcdc_pkg::gear_rom_type GEAR_ROM = gcdc_pkg::gear_rom_build();

   gcdc_pkg::cfg_type cfg;

   gcdc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Input register
   logic                             in_valid_ff, in_valid_in;
   logic [gcdc_pkg::BYTE_W-1:0]      in_byte_ff;
   logic                             in_eos_ff;

   // Chunk state
   logic [gcdc_pkg::MASK_W-1:0]      fp_ff, fp_in;
   logic [LENGTH_BITS-1:0]           pos_ff, pos_in;

   // Result register
   logic                             out_valid_ff, out_valid_in;
   logic [gcdc_pkg::SIZE_W-1:0]      out_length_ff, out_length_in;
   logic [gcdc_pkg::CAUSE_W-1:0]     out_cause_ff, out_cause_in;

   logic                             req_take;
   logic                             advance;
   logic [LENGTH_BITS:0]             length;
   logic [CMP_W-1:0]                 pos_x, length_x, min_x, normal_x, limit_x;
   logic [gcdc_pkg::SIZE_W-1:0]      limit;
   logic                             hash_en;
   logic                             strict;
   logic [gcdc_pkg::MASK_W-1:0]      fp_next;
   logic [gcdc_pkg::MASK_W-1:0]      mask;
   logic                             mask_hit;
   logic                             max_hit;
   logic                             cut;
   logic [gcdc_pkg::CAUSE_W-1:0]     cause;

   // Handshake: process when the result slot is free or draining
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   // Position compares, widened past both the counter and the size fields
   assign length   = {1'b0, pos_ff} + {{LENGTH_BITS{1'b0}}, 1'b1};
   assign limit    = (cfg.max_size == '0) ? gcdc_pkg::SIZE_W'(1) : cfg.max_size;
   assign pos_x    = CMP_W'(pos_ff);
   assign length_x = CMP_W'(length);
   assign min_x    = CMP_W'(cfg.min_size);
   assign normal_x = CMP_W'(cfg.normal_size);
   assign limit_x  = CMP_W'(limit);

   assign hash_en  = (pos_x >= min_x) && (pos_x < limit_x);
   assign strict   = pos_x < normal_x;

   // Gear shift-add and mask test
   assign fp_next  = {fp_ff[gcdc_pkg::MASK_W-2:0], 1'b0} + GEAR_ROM[in_byte_ff];
   assign mask     = strict ? cfg.strict_mask : cfg.loose_mask;
   assign mask_hit = hash_en && ((fp_next & mask) == '0);
   assign max_hit  = (length_x >= limit_x) || (length >= LEN_LIMIT);
   assign cut      = mask_hit || max_hit || in_eos_ff;

   // Pick the cause: mask, then max size, then end of stream
   always_comb begin
      if (mask_hit) begin
         cause = strict ? gcdc_pkg::CAUSE_STRICT : gcdc_pkg::CAUSE_LOOSE;
      end else if (max_hit) begin
         cause = gcdc_pkg::CAUSE_MAX;
      end else begin
         cause = gcdc_pkg::CAUSE_EOS;
      end
   end

   // Next state
   always_comb begin
      in_valid_in   = in_valid_ff;
      fp_in         = fp_ff;
      pos_in        = pos_ff;
      out_length_in = out_length_ff;
      out_cause_in  = out_cause_ff;
      out_valid_in  = out_valid_ff && !rsp_chan.ready;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_take) begin
         in_valid_in = 1'b1;
      end

      if (advance) begin
         if (cut) begin
            fp_in         = '0;
            pos_in        = '0;
            out_valid_in  = 1'b1;
            out_length_in = length_x[gcdc_pkg::SIZE_W-1:0];
            out_cause_in  = cause;
         end else begin
            if (hash_en) begin
               fp_in = fp_next;
            end
            pos_in = length[LENGTH_BITS-1:0];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         fp_ff        <= '0;
         pos_ff       <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         fp_ff        <= fp_in;
         pos_ff       <= pos_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.data_byte;
         in_eos_ff  <= req_chan.end_of_stream;
      end
      out_length_ff <= out_length_in;
      out_cause_ff  <= out_cause_in;
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.chunk_length = out_length_ff;
   assign rsp_chan.cut_cause    = out_cause_ff;

endmodule

`default_nettype wire
